>>> sv/tlcg_pkg.sv
// Shared types, register indexes and the sine table function for the chirp generator.
package tlcg_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_X_START   = 3'd0,
    REG_X_RAMP    = 3'd1,
    REG_Y_START   = 3'd2,
    REG_Y_RAMP    = 3'd3,
    REG_Z_START   = 3'd4,
    REG_Z_RAMP    = 3'd5,
    REG_AMPLITUDE = 3'd6
  } cfg_reg_t;

  localparam int unsigned NUM_AXES      = 3;
  localparam int unsigned CFG_WIDTH     = 32;
  localparam int unsigned AMP_WIDTH     = 15;
  localparam int unsigned SAMPLE_WIDTH  = 16;
  localparam logic [AMP_WIDTH-1:0] AMP_RESET = 15'd32766;
  localparam real HALF_PI  = 1.5707963267948966;
  localparam real SINE_PEAK = 32767.0;

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;

  // Entry idx of a full-wave table of 2^addr_bits points: round(32767*sin)
  function automatic sample_t sine_entry(input int addr_bits, input int idx);
    int  qs;
    int  q;
    int  j;
    int  k;
    int  m;
    real ang;
    qs  = 1 << (addr_bits - 2);
    q   = (idx >> (addr_bits - 2)) & 3;
    j   = idx & (qs - 1);
    k   = ((q & 1) != 0) ? (qs - j) : j;
    ang = HALF_PI * real'(k) * (2.0 ** (2 - addr_bits));
    m   = $rtoi(SINE_PEAK * $sin(ang) + 0.5);
    if ((q & 2) != 0) begin
      m = -m;
    end
    return sample_t'(m);
  endfunction

endpackage

>>> sv/three_axis_linear_chirp_generator.sv
// Three-axis linear chirp generator: per-axis phase/step accumulators, sine ROM and scaling.
//
// One sample beat in gives one three-axis sample beat out; a new beat is taken every clock
// while in_stall is low, so the block runs at one sample per cycle unless stalled. The sine
// ROM read is registered and the amplitude multiply feeds the output register. The phase and
// step accumulators update with one addition each at the moment a beat is taken, so back to
// back beats see the updated state. A beat with restart set zeroes the phases and reloads the
// steps from the start step registers before its sample is formed; start step writes take
// effect only at the next restart. Configuration is accepted every cycle (cfg_ready is tied
// high); writes to indexes beyond the amplitude register are dropped.
module three_axis_linear_chirp_generator
  import tlcg_pkg::*;
#(
  parameter int unsigned PHASE_BITS     = 32,
  parameter int unsigned SINE_ADDR_BITS = 10
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // configuration write channel
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [2:0]               cfg_index,
  input  logic [CFG_WIDTH-1:0]     cfg_data,
  // sample request channel
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_restart,
  // sample result channel
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [15:0]       out_x_sample,
  output logic signed [15:0]       out_y_sample,
  output logic signed [15:0]       out_z_sample
);

  localparam int unsigned TBL_SIZE = 1 << SINE_ADDR_BITS;

  typedef logic [PHASE_BITS-1:0]     phase_t;
  typedef logic [SINE_ADDR_BITS-1:0] addr_t;
  typedef sample_t                   rom_t [TBL_SIZE];

  function automatic rom_t build_rom();
    rom_t rom;
    for (int i = 0; i < int'(TBL_SIZE); i++) begin
      rom[i] = sine_entry(int'(SINE_ADDR_BITS), i);
    end
    return rom;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  // configuration registers
  logic [CFG_WIDTH-1:0] start_r [NUM_AXES];
  logic [CFG_WIDTH-1:0] ramp_r  [NUM_AXES];
  logic [AMP_WIDTH-1:0] amp_r;

  // accumulators
  phase_t phase_r [NUM_AXES];
  phase_t step_r  [NUM_AXES];
  phase_t phase_nxt [NUM_AXES];
  phase_t step_nxt  [NUM_AXES];
  phase_t base_phase [NUM_AXES];
  phase_t base_step  [NUM_AXES];
  phase_t start_ext  [NUM_AXES];
  phase_t ramp_ext   [NUM_AXES];
  addr_t  rom_addr   [NUM_AXES];

  // pipeline
  logic    rd_valid_r;
  sample_t rd_data_r [NUM_AXES];
  logic    out_valid_r;
  sample_t out_sample_r [NUM_AXES];
  sample_t sample_nxt   [NUM_AXES];

  logic out_en;
  logic rd_en;
  logic in_take;

  assign cfg_ready = 1'b1;

  // advance the output register when empty or drained; fill the read stage into any gap
  assign out_en   = !out_valid_r || !out_stall;
  assign rd_en    = out_en || !rd_valid_r;
  assign in_stall = !rd_en;
  assign in_take  = in_valid && rd_en;

  // extend register values to the phase width
  always_comb begin
    logic [PHASE_BITS+CFG_WIDTH-1:0] s_wide;
    logic [PHASE_BITS+CFG_WIDTH-1:0] r_wide;
    for (int a = 0; a < int'(NUM_AXES); a++) begin
      s_wide        = {{PHASE_BITS{1'b0}}, start_r[a]};
      r_wide        = {{PHASE_BITS{ramp_r[a][CFG_WIDTH-1]}}, ramp_r[a]};
      start_ext[a]  = s_wide[PHASE_BITS-1:0];
      ramp_ext[a]   = r_wide[PHASE_BITS-1:0];
      base_phase[a] = in_restart ? '0 : phase_r[a];
      base_step[a]  = in_restart ? start_ext[a] : step_r[a];
      phase_nxt[a]  = base_phase[a] + base_step[a];
      step_nxt[a]   = base_step[a] + ramp_ext[a];
      rom_addr[a]   = base_phase[a][PHASE_BITS-1 -: SINE_ADDR_BITS];
    end
  end

  // scale and round the table value
  always_comb begin
    logic signed [AMP_WIDTH+SAMPLE_WIDTH:0] prod;
    for (int a = 0; a < int'(NUM_AXES); a++) begin
      prod          = $signed({1'b0, amp_r}) * rd_data_r[a]
                      + $signed((AMP_WIDTH+SAMPLE_WIDTH+1)'(16384));
      sample_nxt[a] = sample_t'(prod >>> 15);
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < int'(NUM_AXES); a++) begin
        start_r[a] <= '0;
        ramp_r[a]  <= '0;
      end
      amp_r <= AMP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_X_START:   start_r[0] <= cfg_data;
        REG_X_RAMP:    ramp_r[0]  <= cfg_data;
        REG_Y_START:   start_r[1] <= cfg_data;
        REG_Y_RAMP:    ramp_r[1]  <= cfg_data;
        REG_Z_START:   start_r[2] <= cfg_data;
        REG_Z_RAMP:    ramp_r[2]  <= cfg_data;
        REG_AMPLITUDE: amp_r      <= cfg_data[AMP_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // advance accumulators on each accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < int'(NUM_AXES); a++) begin
        phase_r[a] <= '0;
        step_r[a]  <= '0;
      end
    end else if (in_take) begin
      for (int a = 0; a < int'(NUM_AXES); a++) begin
        phase_r[a] <= phase_nxt[a];
        step_r[a]  <= step_nxt[a];
      end
    end
  end

  // sine ROM read stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_valid_r <= 1'b0;
    end else if (rd_en) begin
      rd_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      for (int a = 0; a < int'(NUM_AXES); a++) begin
        rd_data_r[a] <= SINE_ROM[rom_addr[a]];
      end
    end
  end

  // output register: hold while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_en) begin
      out_valid_r <= rd_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en && rd_valid_r) begin
      for (int a = 0; a < int'(NUM_AXES); a++) begin
        out_sample_r[a] <= sample_nxt[a];
      end
    end
  end

  assign out_valid    = out_valid_r;
  assign out_x_sample = out_sample_r[0];
  assign out_y_sample = out_sample_r[1];
  assign out_z_sample = out_sample_r[2];

endmodule
